### design/lsph_pkg.sv
// ----------------------------------------------------------------------------
// lsph_pkg
// Shared widths, constants and types for the LCG seed position histogram.
// ----------------------------------------------------------------------------
package lsph_pkg;

    // Seed and generator step constants
    localparam int SEED_BITS = 48;
    localparam int HALF_BITS = SEED_BITS / 2;
    localparam logic [HALF_BITS-1:0] LCG_MUL_LO = 24'hECE66D;  // low half of 0x5DEECE66D
    localparam logic [HALF_BITS-1:0] LCG_MUL_HI = 24'h0005DE;  // high part of 0x5DEECE66D
    localparam logic [SEED_BITS-1:0] LCG_ADD    = 48'hB;

    // Bin counters
    localparam int COUNT_BITS = 48;
    localparam int NUM_BINS   = 768;

    // Bin coordinates; bin index is {z, y, x} = x + 4*y + 128*z
    localparam int X_BITS  = 2;
    localparam int Y_BITS  = 5;
    localparam int Z_BITS  = 3;
    localparam int BIN_AW  = X_BITS + Y_BITS + Z_BITS;
    localparam logic [X_BITS-1:0] X_LAST = 2'd3;
    localparam logic [Y_BITS-1:0] Y_LAST = 5'd31;
    localparam logic [Z_BITS-1:0] Z_LAST = 3'd5;
    localparam logic [3:0]        Z_NIB_OFFSET = 4'd10;

    // Stream payload widths
    localparam int IN_TDATA_BITS  = SEED_BITS;
    localparam int OUT_BITS       = X_BITS + Y_BITS + Z_BITS + SEED_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    // Item kinds
    localparam logic KIND_TALLY = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Classification result of the step unit
    typedef struct packed {
        logic              done;
        logic              pass;
        logic [X_BITS-1:0] x;
        logic [Y_BITS-1:0] y;
        logic [Z_BITS-1:0] z;
    } t_lcg_res;

endpackage

### design/lsph_ram.sv
// ----------------------------------------------------------------------------
// lsph_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lsph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/lsph_lcg.sv
// ----------------------------------------------------------------------------
// lsph_lcg
// Three-step 48-bit LCG unit: each step runs in two phases, early reject on x and z.
// ----------------------------------------------------------------------------
module lsph_lcg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [lsph_pkg::SEED_BITS-1:0]   i_seed,
    output lsph_pkg::t_lcg_res               o_res
);
    import lsph_pkg::*;

    localparam logic [1:0] STEP_X = 2'd0;
    localparam logic [1:0] STEP_Z = 2'd1;
    localparam logic [1:0] STEP_Y = 2'd2;

    logic                 r_busy;
    logic                 r_phase;
    logic [1:0]           r_step;
    logic [SEED_BITS-1:0] r_seed;
    logic [SEED_BITS-1:0] r_acc;
    logic                 r_done;
    logic                 r_pass;
    logic [X_BITS-1:0]    r_x;
    logic [Y_BITS-1:0]    r_y;
    logic [Z_BITS-1:0]    r_z;

    logic [SEED_BITS-1:0] w_lo;
    logic [HALF_BITS-1:0] w_cross_a;
    logic [HALF_BITS-1:0] w_cross_b;
    logic [SEED_BITS-1:0] w_next;
    logic [3:0]           w_nib;
    logic [3:0]           w_zoff;

    // low partial product plus increment (phase 0)
    assign w_lo = SEED_BITS'(r_seed[HALF_BITS-1:0]) * SEED_BITS'(LCG_MUL_LO) + LCG_ADD;

    // cross terms, only their low half survives mod 2^48 (phase 1)
    assign w_cross_a = r_seed[HALF_BITS-1:0] * LCG_MUL_HI;
    assign w_cross_b = r_seed[SEED_BITS-1:HALF_BITS] * LCG_MUL_LO;
    assign w_next    = r_acc + {w_cross_a + w_cross_b, {HALF_BITS{1'b0}}};
    assign w_nib     = w_next[SEED_BITS-1 -: 4];
    assign w_zoff    = w_nib - Z_NIB_OFFSET;

    // step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_step  <= STEP_X;
            r_done  <= 1'b0;
            r_pass  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_step  <= STEP_X;
                r_seed  <= i_seed;
            end else if (r_busy) begin
                if (!r_phase) begin
                    r_acc   <= w_lo;
                    r_phase <= 1'b1;
                end else begin
                    r_phase <= 1'b0;
                    r_seed  <= w_next;
                    case (r_step)
                        STEP_X: begin
                            r_x <= w_nib[X_BITS-1:0];
                            if (w_nib[3:X_BITS] != '0) begin
                                r_busy <= 1'b0;
                                r_done <= 1'b1;
                                r_pass <= 1'b0;
                            end else begin
                                r_step <= STEP_Z;
                            end
                        end
                        STEP_Z: begin
                            r_z <= w_zoff[Z_BITS-1:0];
                            if (w_nib < Z_NIB_OFFSET) begin
                                r_busy <= 1'b0;
                                r_done <= 1'b1;
                                r_pass <= 1'b0;
                            end else begin
                                r_step <= STEP_Y;
                            end
                        end
                        STEP_Y: begin
                            r_y    <= w_next[SEED_BITS-1 -: Y_BITS];
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            r_pass <= 1'b1;
                        end
                        default: begin
                            r_busy <= 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.pass = r_pass;
    assign o_res.x    = r_x;
    assign o_res.y    = r_y;
    assign o_res.z    = r_z;

endmodule

### design/lcg_seed_position_histogram.sv
// ----------------------------------------------------------------------------
// lcg_seed_position_histogram
// Classifies candidate seeds into 768 saturating bins and reports the
// most frequent bin on request.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser[0] = kind (0 tally, 1 query), tdata = candidate seed.
//   Master stream: one transaction per query, none per tally.
//   Items are handled one at a time; tready is high only when the block is idle.
//   Tally: a passing seed runs three LCG steps, then the counter read,
//     write-back and the idle accept state; a seed rejected on x or on z
//     goes back to idle after that step, with no counter access.
//   Query: the counter RAM is read once per bin in scan order (x outer,
//     y, z inner), one read per cycle.
//   Reset: control state and any pending result are dropped and a clearing
//     pass writes zero to all 768 counters, during which tready stays low.
//   Stall: the result sits in an output register; further tallies are taken
//     while it waits, and a second query finishes only once it is taken.
// ----------------------------------------------------------------------------
module lcg_seed_position_histogram (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [lsph_pkg::IN_TDATA_BITS-1:0]   i_s_axis_tdata,  // [47:0] candidate_seed
    input  logic [0:0]                           i_s_axis_tuser,  // [0] kind
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [1:0] best_x, [6:2] best_y, [9:7] best_z, [57:10] best_count, rest zero
    output logic [lsph_pkg::OUT_TDATA_BITS-1:0]  o_m_axis_tdata
);
    import lsph_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LCG   = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [BIN_AW-1:0]     r_addr;
    logic [X_BITS-1:0]     r_sx;
    logic [Y_BITS-1:0]     r_sy;
    logic [Z_BITS-1:0]     r_sz;
    logic                  r_cmp_v;
    logic [X_BITS-1:0]     r_cx;
    logic [Y_BITS-1:0]     r_cy;
    logic [Z_BITS-1:0]     r_cz;
    logic [COUNT_BITS-1:0] r_best;
    logic [X_BITS-1:0]     r_bx;
    logic [Y_BITS-1:0]     r_by;
    logic [Z_BITS-1:0]     r_bz;
    logic                  r_m_tvalid;
    logic [OUT_TDATA_BITS-1:0] r_m_tdata;

    logic                  w_s_accept;
    logic                  w_start;
    logic                  w_out_free;
    logic                  w_scan_last;
    t_lcg_res              w_lcg;

    logic                  w_we;
    logic [BIN_AW-1:0]     w_waddr;
    logic [COUNT_BITS-1:0] w_wdata;
    logic                  w_re;
    logic [BIN_AW-1:0]     w_raddr;
    logic [COUNT_BITS-1:0] w_rdata;
    logic [SEED_BITS+COUNT_BITS-1:0] w_best_ext;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_start         = w_s_accept && (i_s_axis_tuser[0] == KIND_TALLY);
    assign w_out_free      = !r_m_tvalid || i_m_axis_tready;
    assign w_scan_last     = (r_sx == X_LAST) && (r_sy == Y_LAST) && (r_sz == Z_LAST);

    // LCG step unit
    lsph_lcg u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_seed  (i_s_axis_tdata[SEED_BITS-1:0]),
        .o_res   (w_lcg)
    );

    // bin counter memory
    lsph_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // memory port control: clear sweep, tally read-modify-write, scan reads
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = '0;
        w_re    = 1'b0;
        w_raddr = {w_lcg.z, w_lcg.y, w_lcg.x};
        case (r_state)
            ST_CLEAR: begin
                w_we = 1'b1;
            end
            ST_LCG: begin
                w_re = w_lcg.done && w_lcg.pass;
            end
            ST_WRITE: begin
                w_we    = 1'b1;
                w_wdata = (&w_rdata) ? w_rdata : w_rdata + COUNT_BITS'(1);
            end
            ST_SCAN: begin
                w_re    = 1'b1;
                w_raddr = {r_sz, r_sy, r_sx};
            end
            default: begin
                w_re = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_addr == BIN_AW'(NUM_BINS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_s_accept) begin
                    n_state = (i_s_axis_tuser[0] == KIND_QUERY) ? ST_SCAN : ST_LCG;
                end
            end
            ST_LCG: begin
                if (w_lcg.done) n_state = w_lcg.pass ? ST_WRITE : ST_IDLE;
            end
            ST_WRITE: begin
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (w_scan_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
            r_cmp_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cmp_v <= (r_state == ST_SCAN);
            if (r_state == ST_CLEAR) begin
                r_addr <= r_addr + BIN_AW'(1);
            end else if (r_state == ST_LCG) begin
                r_addr <= {w_lcg.z, w_lcg.y, w_lcg.x};
            end
        end
    end

    // scan counters and running maximum
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_sx   <= '0;
            r_sy   <= '0;
            r_sz   <= '0;
            r_best <= '0;
            r_bx   <= '0;
            r_by   <= '0;
            r_bz   <= '0;
        end else begin
            if (r_state == ST_SCAN) begin
                r_cx <= r_sx;
                r_cy <= r_sy;
                r_cz <= r_sz;
                if (r_sz == Z_LAST) begin
                    r_sz <= '0;
                    r_sy <= r_sy + Y_BITS'(1);
                    if (r_sy == Y_LAST) r_sx <= r_sx + X_BITS'(1);
                end else begin
                    r_sz <= r_sz + Z_BITS'(1);
                end
            end
            // strict greater-than keeps the earliest bin on ties
            if (r_cmp_v && (w_rdata > r_best)) begin
                r_best <= w_rdata;
                r_bx   <= r_cx;
                r_by   <= r_cy;
                r_bz   <= r_cz;
            end
        end
    end

    // output register
    assign w_best_ext = {{SEED_BITS{1'b0}}, r_best};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if ((r_state == ST_OUT) && w_out_free) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && w_out_free) begin
            r_m_tdata <= {(OUT_TDATA_BITS - OUT_BITS)'(0),
                          w_best_ext[SEED_BITS-1:0], r_bz, r_by, r_bx};
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;

endmodule

### design/lsph_chk.sv
// ----------------------------------------------------------------------------
// lsph_chk
// Port-level checks for the LCG seed position histogram.
// ----------------------------------------------------------------------------
module lsph_chk (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_s_axis_tready,
    input  logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    input  logic [lsph_pkg::OUT_TDATA_BITS-1:0]  o_m_axis_tdata
);
    import lsph_pkg::*;

    // reset drops any pending result
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // no item is taken while the clearing pass starts
    a_clear_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_s_axis_tready)
        else $error("input ready during clearing pass");

    // best_z only ever names one of six z rows
    a_z_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[9:7] <= Z_LAST))
        else $error("best_z out of range");

    // an empty histogram reports the first bin
    a_empty_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[57:10] == '0) |-> (o_m_axis_tdata[9:0] == '0))
        else $error("zero count with nonzero coordinates");

endmodule

bind lcg_seed_position_histogram lsph_chk u_lsph_chk (.*);

### tb/lcg_seed_position_histogram_tb.sv
// ----------------------------------------------------------------------------
// lcg_seed_position_histogram_tb
// Self-checking bench for the seed histogram. Tally and query transactions
// are streamed in. A local histogram is updated on every accepted tally
// and predicts each query answer. Test tasks cover the directed
// corners, four idle/stall phases of random traffic and a long output hold
// that backs the block up.
// ----------------------------------------------------------------------------
module lcg_seed_position_histogram_tb;
    import lsph_pkg::*;

    // Drain wait after the last result
    localparam int SETTLE_CYCLES = 16;
    localparam logic [SEED_BITS-1:0] SEED_MUL = {LCG_MUL_HI, LCG_MUL_LO};

    typedef enum logic [1:0] {
        SEED_PASS,
        SEED_REJECT_X,
        SEED_REJECT_Z
    } t_seed_verdict;

    typedef struct packed {
        t_seed_verdict     verdict;
        logic [Z_BITS-1:0] z;
        logic [Y_BITS-1:0] y;
        logic [X_BITS-1:0] x;
    } t_seed_bin;

    // Same bit order as the master tdata, lowest field last
    typedef struct packed {
        logic [SEED_BITS-1:0] count;
        logic [Z_BITS-1:0]    z;
        logic [Y_BITS-1:0]    y;
        logic [X_BITS-1:0]    x;
    } t_best_bin;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_s_axis_tvalid = 1'b0;
    logic                      o_s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata = '0;   // [47:0] candidate_seed
    logic [0:0]                i_s_axis_tuser = '0;   // [0] kind
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready = 1'b0;
    // [1:0] best_x, [6:2] best_y, [9:7] best_z, [57:10] best_count
    logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata;

    // Local copy of the bin counters and the answers still owed
    logic [COUNT_BITS-1:0] bin_count [NUM_BINS];
    t_best_bin             expected_best [$];

    int fail_count = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;

    lcg_seed_position_histogram uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Covers every item being a query under the heaviest stalls, several times
    initial begin
        #100_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        foreach (bin_count[i]) bin_count[i] = '0;
    end

    // ------------------------------------------------------------------
    // Histogram prediction
    // ------------------------------------------------------------------
    function automatic logic [SEED_BITS-1:0] lcg_next(input logic [SEED_BITS-1:0] s);
        return s * SEED_MUL + LCG_ADD;
    endfunction

    function automatic t_seed_bin locate_bin(input logic [SEED_BITS-1:0] seed);
        logic [SEED_BITS-1:0] s;
        t_seed_bin            r;
        r = '0;
        s = lcg_next(seed);
        if (s[47:44] >= 4'd4) begin
            r.verdict = SEED_REJECT_X;
            return r;
        end
        r.x = s[45:44];
        s = lcg_next(s);
        if (s[47:44] < Z_NIB_OFFSET) begin
            r.verdict = SEED_REJECT_Z;
            return r;
        end
        r.z = Z_BITS'(s[47:44] - Z_NIB_OFFSET);
        s = lcg_next(s);
        r.y = s[47:43];
        r.verdict = SEED_PASS;
        return r;
    endfunction

    function automatic void tally_seed(input logic [SEED_BITS-1:0] seed);
        t_seed_bin p;
        p = locate_bin(seed);
        // counters stick at all ones
        if (p.verdict == SEED_PASS && bin_count[{p.z, p.y, p.x}] != '1)
            bin_count[{p.z, p.y, p.x}] += 1'b1;
    endfunction

    // x outer, y, z inner; strict compare keeps the earliest of a tie
    function automatic t_best_bin predict_best_bin();
        t_best_bin             b;
        logic [COUNT_BITS-1:0] top;
        logic [COUNT_BITS-1:0] c;
        b = '0;
        top = '0;
        for (int x = 0; x < 4; x++) begin
            for (int y = 0; y < 32; y++) begin
                for (int z = 0; z < 6; z++) begin
                    c = bin_count[x + 4 * y + 128 * z];
                    if (c > top) begin
                        top = c;
                        b.x = X_BITS'(x);
                        b.y = Y_BITS'(y);
                        b.z = Z_BITS'(z);
                    end
                end
            end
        end
        b.count = top[SEED_BITS-1:0];
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Seed generation
    // ------------------------------------------------------------------
    function automatic logic [SEED_BITS-1:0] random_seed();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[SEED_BITS-1:0];
    endfunction

    // Draw seeds until one meets the wanted verdict (and bin, if asked)
    function automatic logic [SEED_BITS-1:0] find_seed(input t_seed_verdict want,
                                                      input logic [BIN_AW-1:0] target,
                                                      input bit any_bin);
        logic [SEED_BITS-1:0] seed;
        t_seed_bin            p;
        do begin
            seed = random_seed();
            p = locate_bin(seed);
        end while (p.verdict != want ||
                   (want == SEED_PASS && !any_bin && {p.z, p.y, p.x} != target));
        return seed;
    endfunction

    // ------------------------------------------------------------------
    // Slave side: one transaction per call, optional idle gap afterwards
    // ------------------------------------------------------------------
    task automatic send_item(input logic kind, input logic [SEED_BITS-1:0] seed);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= seed;
        i_s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (kind == KIND_TALLY)
            tally_seed(seed);
        else
            expected_best.push_back(predict_best_bin());
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic finish_phase();
        i_s_axis_tvalid <= 1'b0;
        while (expected_best.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Master side: random stalls plus an optional long hold
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left    <= rx_hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Check each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_best_bin got;
        t_best_bin want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_best_bin'(o_m_axis_tdata[OUT_BITS-1:0]);
            if (expected_best.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d count=%0d",
                         $time, got.x, got.y, got.z, got.count);
                fail_count++;
            end else begin
                want = expected_best.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch exp x=%0d y=%0d z=%0d count=%0d",
                             $time, want.x, want.y, want.z, want.count);
                    $display("%0t:          got x=%0d y=%0d z=%0d count=%0d",
                             $time, got.x, got.y, got.z, got.count);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fresh histogram answers all zero; query payload is ignored
    task automatic test_empty_histogram();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        send_item(KIND_QUERY, '1);
        send_item(KIND_QUERY, '0);
        finish_phase();
    endtask

    task automatic test_seed_extremes();
        send_item(KIND_TALLY, '0);
        send_item(KIND_TALLY, '1);
        send_item(KIND_QUERY, '0);
        finish_phase();
    endtask

    // Seeds failing the x test and the z test leave the bins alone
    task automatic test_rejected_seeds();
        send_item(KIND_TALLY, find_seed(SEED_REJECT_X, '0, 1'b1));
        send_item(KIND_TALLY, find_seed(SEED_REJECT_Z, '0, 1'b1));
        send_item(KIND_QUERY, random_seed());
        finish_phase();
    endtask

    // Equal counts: the bin earlier in scan order wins; then the last bin
    // (x=3, y=31, z=5) pulls ahead
    task automatic test_tie_break();
        logic [SEED_BITS-1:0] last_seed;
        logic [SEED_BITS-1:0] prior_seed;
        last_seed  = find_seed(SEED_PASS, {Z_LAST, Y_LAST, X_LAST}, 1'b0);
        prior_seed = find_seed(SEED_PASS, {Z_LAST - 3'd1, Y_LAST, X_LAST}, 1'b0);
        repeat (3) send_item(KIND_TALLY, last_seed);
        repeat (3) send_item(KIND_TALLY, prior_seed);
        send_item(KIND_QUERY, random_seed());
        send_item(KIND_TALLY, last_seed);
        send_item(KIND_QUERY, random_seed());
        finish_phase();
    endtask

    // Mostly passing seeds, some reused to build up counts, some raw noise
    task automatic test_random_traffic(input int n, input int tx_pct, input int rx_pct);
        logic [SEED_BITS-1:0] pool [16];
        int                   pick;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        foreach (pool[i]) pool[i] = find_seed(SEED_PASS, '0, 1'b1);
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 5)
                send_item(KIND_QUERY, random_seed());
            else if (pick < 40)
                send_item(KIND_TALLY, pool[$urandom_range(15)]);
            else if (pick < 75)
                send_item(KIND_TALLY, find_seed(SEED_PASS, '0, 1'b1));
            else
                send_item(KIND_TALLY, random_seed());
        end
        finish_phase();
    endtask

    // Output held off long enough that a waiting result blocks a second query
    task automatic test_output_hold();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_left = 3000;
        repeat (3) begin
            send_item(KIND_QUERY, random_seed());
            repeat (4) send_item(KIND_TALLY, find_seed(SEED_PASS, '0, 1'b1));
        end
        finish_phase();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_histogram();
        test_seed_extremes();
        test_rejected_seeds();
        test_tie_break();
        test_random_traffic(425, 0, 0);
        test_random_traffic(425, 77, 0);
        test_random_traffic(425, 0, 77);
        test_random_traffic(425, 6, 6);
        test_output_hold();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
design/lsph_pkg.sv
design/lsph_ram.sv
design/lsph_lcg.sv
design/lcg_seed_position_histogram.sv
design/lsph_chk.sv
tb/lcg_seed_position_histogram_tb.sv
